[design/pgr_pkg.sv]
// Shared widths and constants of the polygon grid rasterizer.
package pgr_pkg;

  localparam int COORD_W    = 32;
  localparam int TAG_W      = 24;
  localparam int ROW_BITS_W = 64;
  localparam int ROW_IDX_W  = 6;
  localparam int ORIGIN_W   = 16;
  localparam int DIM_W      = 7;

  // Reset value of the reciprocal bin size (1.0 in 16.16).
  localparam logic [COORD_W-1:0] INV_RESET = 32'h0001_0000;

  // Slope datapath: the magnitude saturates at 2^40.
  localparam int SLOPE_W = 41;
  localparam int M_W     = 42;
  localparam logic [SLOPE_W-1:0] SLOPE_LIMIT = 41'h100_0000_0000;

  // Divider operands: dy shifted up by 16 over dx.
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 32;

  // Walk accumulator and bin row values.
  localparam int Y_W    = 50;
  localparam int ROWV_W = 34;
  localparam int PROD_W = 58;

endpackage

[design/pgr_div.sv]
// Restoring divider for the edge slope, one quotient bit per cycle.
module pgr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pgr_pkg::DIV_N_W-1:0] dividend,
  input  logic [pgr_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [pgr_pkg::DIV_N_W-1:0] quotient
);
  import pgr_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] dsr;
  logic [DIV_N_W-1:0] qreg;
  logic [DIV_D_W:0]   rem_sh;
  logic [DIV_D_W:0]   rem_sub;
  logic               take;

  // Shift in the next dividend bit and try a subtraction.
  assign rem_sh   = {rem, qreg[DIV_N_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dsr};
  assign take     = rem_sh >= {1'b0, dsr};
  assign quotient = qreg;

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= divisor;
      qreg <= dividend;
    end else if (busy) begin
      rem  <= take ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      qreg <= {qreg[DIV_N_W-2:0], take};
    end
  end

  // A new start never comes while the divider runs.
  property p_no_restart;
    @(posedge clk) disable iff (rst) busy |-> !start;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

  property p_done_pulse;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("divider done held high");

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without a run");

endmodule

[design/polygon_grid_rasterizer.sv]
// Polygon grid rasterizer top level: edge store, occupancy grid and walk sequencer.
//
//   channel | signals                                    | transfer
//   --------+--------------------------------------------+---------------------------
//   cfg     | cfg_write_en, cfg_write_data               | write when enable is high
//   in      | in_valid, in_ready, cell_tag..last_edge    | one edge per request
//   out     | out_valid, out_ready, row_bits..last_row   | one grid row per request
//
// An edge that is not last is scaled by four 32x32 products and written once to the store.
// A last edge adds: clearing grid_height rows, a walk of each edge with a divider run for
// sloped edges and a read then write of the grid memory per marked row, a read, update
// and write per interior fill row, and a read per emitted row.
// Reset is synchronous and needs no clearing pass; the grid is cleared per polygon.
// A stalled output holds the sequencer in its emit step; in_ready is high only when idle.
module polygon_grid_rasterizer #(
  parameter int GRID_SIZE = 64,
  parameter int MAX_EDGES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [pgr_pkg::COORD_W-1:0]    cfg_write_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pgr_pkg::TAG_W-1:0]      cell_tag,
  input  logic [pgr_pkg::COORD_W-1:0]    ax,
  input  logic [pgr_pkg::COORD_W-1:0]    ay,
  input  logic [pgr_pkg::COORD_W-1:0]    bx,
  input  logic [pgr_pkg::COORD_W-1:0]    by,
  input  logic                           last_edge,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pgr_pkg::ROW_BITS_W-1:0] row_bits,
  output logic [pgr_pkg::ROW_IDX_W-1:0]  row_index,
  output logic [pgr_pkg::ORIGIN_W-1:0]   origin_x,
  output logic [pgr_pkg::ORIGIN_W-1:0]   origin_y,
  output logic [pgr_pkg::DIM_W-1:0]      grid_width,
  output logic [pgr_pkg::DIM_W-1:0]      grid_height,
  output logic [pgr_pkg::TAG_W-1:0]      tag_out,
  output logic                           too_large,
  output logic                           last_row
);
  import pgr_pkg::*;

  localparam int ROW_W = $clog2(GRID_SIZE);
  localparam int DW    = $clog2(GRID_SIZE + 1);
  localparam int EW    = $clog2(MAX_EDGES);
  localparam int CW    = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W = 4 * COORD_W;

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_SCALE      = 5'd1;
  localparam logic [4:0] S_STORE      = 5'd2;
  localparam logic [4:0] S_BOX        = 5'd3;
  localparam logic [4:0] S_CLEAR      = 5'd4;
  localparam logic [4:0] S_EDGE_RD    = 5'd5;
  localparam logic [4:0] S_EDGE_LD    = 5'd6;
  localparam logic [4:0] S_EDGE_SETUP = 5'd7;
  localparam logic [4:0] S_DIV        = 5'd8;
  localparam logic [4:0] S_MUL        = 5'd9;
  localparam logic [4:0] S_FIRST      = 5'd10;
  localparam logic [4:0] S_NEXT_COL   = 5'd11;
  localparam logic [4:0] S_RUN_START  = 5'd12;
  localparam logic [4:0] S_RUN_RD     = 5'd13;
  localparam logic [4:0] S_RUN_WR     = 5'd14;
  localparam logic [4:0] S_FILL_RD    = 5'd15;
  localparam logic [4:0] S_FILL_A     = 5'd16;
  localparam logic [4:0] S_FILL_B     = 5'd17;
  localparam logic [4:0] S_EMIT_RD    = 5'd18;
  localparam logic [4:0] S_EMIT_LD    = 5'd19;

  logic [4:0]             state;
  logic [COORD_W-1:0]     inv_bin_size;

  // Captured request and scaled coordinates.
  logic [COORD_W-1:0]     in_c [4];
  logic [COORD_W-1:0]     sc_v [4];
  logic                   in_last;
  logic [TAG_W-1:0]       held_tag;
  logic [2:0]             sc_cnt;
  logic [COORD_W-1:0]     sval;
  logic [1:0]             sidx;
  logic [63:0]            sc_prod;
  logic [COORD_W-1:0]     sc_sat;

  // Bounding box and grid size.
  logic [ORIGIN_W-1:0]    min_x, max_x, min_y, max_y;
  logic [CW-1:0]          edge_count;
  logic [CW-1:0]          ek;
  logic [DW-1:0]          cur_w, cur_h;
  logic                   big;
  logic signed [17:0]     dxw, dyh;
  logic [GRID_SIZE-1:0]   wmask, wlim;

  // Edge walk.
  logic [COORD_W-1:0]     x0, y0, xf, yf;
  logic                   vert, pos, m_pos;
  logic signed [M_W-1:0]  m;
  logic signed [PROD_W-1:0] prod;
  logic signed [Y_W-1:0]  yr;
  logic signed [ROWV_W-1:0] lo, hi;
  logic [ROW_W-1:0]       col_cur, col_last;
  logic [ROW_W-1:0]       row, row_end;
  logic [ROW_W-1:0]       h_last;

  // Interior fill.
  logic [GRID_SIZE-1:0]   frow, above1, e2;
  logic [GRID_SIZE-1:0]   fe, fem1, below2;

  // Divider.
  logic                   div_start, div_done;
  logic [DIV_N_W-1:0]     div_q;
  logic [DIV_D_W-1:0]     ady;
  logic [SLOPE_W-1:0]     mag;

  // Memories.
  logic [EDGE_W-1:0]      edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0]      edge_q;
  logic [GRID_SIZE-1:0]   grid_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0]   grid_q;
  logic                   grid_we, grid_re;
  logic [GRID_SIZE-1:0]   grid_wdata;

  logic                   accept, emit_go;
  logic [COORD_W-1:0]     ax_r, ay_r, bx_r, by_r;
  logic [COORD_W-1:0]     ox_w, oy_w;
  logic signed [Y_W-1:0]  yl_first, yr_first, yr_nx, pshift;
  logic signed [ROWV_W-1:0] hmax, yfb, e_nx, s_nx, lo_c, hi_c;
  logic                   run_empty;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit_go  = (state == S_EMIT_LD) && (!out_valid || out_ready);
  assign h_last   = ROW_W'(cur_h - 1'b1);

  // Scaling product for the coordinate in turn, saturated to 32 bits.
  assign sc_prod = in_c[sc_cnt[1:0]] * inv_bin_size;
  assign sc_sat  = (sc_prod[63:48] != '0) ? '1 : sc_prod[47:16];

  // Box extents, clamped to at least one bin.
  assign dxw = $signed({2'b00, max_x}) - $signed({2'b00, min_x}) + 18'sd1;
  assign dyh = $signed({2'b00, max_y}) - $signed({2'b00, min_y}) + 18'sd1;

  // Column masks: valid columns, and columns that can end a boundary run.
  always_comb begin
    for (int i = 0; i < GRID_SIZE; i++) begin
      wmask[i] = (DW+1)'(i) < {1'b0, cur_w};
      wlim[i]  = (DW+1)'(i + 1) < {1'b0, cur_w};
    end
  end

  // Edge endpoints relative to the box origin.
  assign ox_w = {min_x, 16'h0000};
  assign oy_w = {min_y, 16'h0000};
  assign ax_r = edge_q[4*COORD_W-1:3*COORD_W] - ox_w;
  assign bx_r = edge_q[3*COORD_W-1:2*COORD_W] - ox_w;
  assign ay_r = edge_q[2*COORD_W-1:COORD_W] - oy_w;
  assign by_r = edge_q[COORD_W-1:0] - oy_w;

  // Slope magnitude, saturated.
  assign ady = (yf >= y0) ? (yf - y0) : (y0 - yf);
  assign mag = (div_q > DIV_N_W'(SLOPE_LIMIT)) ? SLOPE_LIMIT : div_q[SLOPE_W-1:0];

  // Row span of the first column and of the following columns.
  assign pshift   = Y_W'(prod >>> 16);
  assign yl_first = $signed({18'b0, y0}) - pshift;
  assign yr_first = yl_first + Y_W'(m);
  assign yr_nx    = yr + Y_W'(m);
  assign s_nx     = ROWV_W'(yr >>> 16);
  assign e_nx     = ROWV_W'(yr_nx >>> 16);
  assign yfb      = $signed({18'b0, yf[31:16]});
  assign hmax     = $signed({{(ROWV_W-DW){1'b0}}, cur_h}) - ROWV_W'(1);

  // Clamp of a run to the grid rows.
  assign run_empty = (hi < 0) || (lo > hmax) || (lo > hi);
  assign lo_c      = (lo < 0) ? '0 : lo;
  assign hi_c      = (hi > hmax) ? hmax : hi;

  // First and second run ends of a row for the interior fill.
  assign fe     = grid_q & ~(grid_q >> 1) & wlim;
  assign fem1   = fe - 1'b1;
  assign below2 = ~e2 & (e2 - 1'b1);

  assign div_start = (state == S_EDGE_SETUP) && !vert &&
                     ({1'b0, x0[31:16]} < 17'(cur_w));

  pgr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({ady, 16'h0000}),
    .divisor  (xf - x0),
    .done     (div_done),
    .quotient (div_q)
  );

  // Grid memory port control.
  always_comb begin
    grid_we    = 1'b0;
    grid_re    = 1'b0;
    grid_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        grid_we = 1'b1;
      end
      S_RUN_WR: begin
        grid_we    = 1'b1;
        grid_wdata = grid_q | (GRID_SIZE'(1) << col_cur);
      end
      S_FILL_B: begin
        grid_we    = 1'b1;
        grid_wdata = frow | (above1 & below2 & wlim);
      end
      S_RUN_RD, S_FILL_RD, S_EMIT_RD: begin
        grid_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Occupancy grid: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[row] <= grid_wdata;
    end
    if (grid_re) begin
      grid_q <= grid_mem[row];
    end
  end

  // Edge store: written after scaling, read back during the walk.
  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      edge_mem[edge_count[EW-1:0]] <= {sc_v[0], sc_v[2], sc_v[1], sc_v[3]};
    end
    if (state == S_EDGE_RD) begin
      edge_q <= edge_mem[ek[EW-1:0]];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_bin_size <= INV_RESET;
    end else if (cfg_write_en) begin
      inv_bin_size <= cfg_write_data;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      min_x      <= '1;
      min_y      <= '1;
      max_x      <= '0;
      max_y      <= '0;
      edge_count <= '0;
      held_tag   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            held_tag <= cell_tag;
            in_c[0]  <= ax;
            in_c[1]  <= ay;
            in_c[2]  <= bx;
            in_c[3]  <= by;
            in_last  <= last_edge;
            sc_cnt   <= '0;
            if (edge_count < CW'(MAX_EDGES)) begin
              state <= S_SCALE;
            end else if (last_edge) begin
              state <= S_BOX;
            end
          end
        end
        S_SCALE: begin
          // Product registered first, box update with it in the next cycle.
          if (sc_cnt != 3'd4) begin
            sval <= sc_sat;
            sidx <= sc_cnt[1:0];
          end
          if (sc_cnt != 3'd0) begin
            sc_v[sidx] <= sval;
            if (!sidx[0]) begin
              if (sval[31:16] < min_x) min_x <= sval[31:16];
              if (sval[31:16] > max_x) max_x <= sval[31:16];
            end else begin
              if (sval[31:16] < min_y) min_y <= sval[31:16];
              if (sval[31:16] > max_y) max_y <= sval[31:16];
            end
          end
          sc_cnt <= sc_cnt + 1'b1;
          if (sc_cnt == 3'd4) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          edge_count <= edge_count + 1'b1;
          state      <= in_last ? S_BOX : S_IDLE;
        end
        S_BOX: begin
          big   <= (dxw > 18'(GRID_SIZE)) || (dyh > 18'(GRID_SIZE));
          cur_w <= (dxw < 18'sd1) ? DW'(1) :
                   (dxw > 18'(GRID_SIZE)) ? DW'(GRID_SIZE) : dxw[DW-1:0];
          cur_h <= (dyh < 18'sd1) ? DW'(1) :
                   (dyh > 18'(GRID_SIZE)) ? DW'(GRID_SIZE) : dyh[DW-1:0];
          row   <= '0;
          state <= S_CLEAR;
        end
        S_CLEAR: begin
          if (row == h_last) begin
            ek    <= '0;
            state <= (edge_count == '0) ? S_EMIT_RD : S_EDGE_RD;
            row   <= '0;
            if (edge_count != '0) begin
              state <= S_EDGE_RD;
            end
          end else begin
            row <= row + 1'b1;
          end
        end
        S_EDGE_RD: begin
          state <= S_EDGE_LD;
        end
        S_EDGE_LD: begin
          vert <= (ax_r == bx_r);
          if (ax_r < bx_r) begin
            x0 <= ax_r; y0 <= ay_r; xf <= bx_r; yf <= by_r;
          end else begin
            x0 <= bx_r; y0 <= by_r; xf <= ax_r; yf <= ay_r;
          end
          state <= S_EDGE_SETUP;
        end
        S_EDGE_SETUP: begin
          pos     <= (yf >= y0);
          col_cur <= x0[ROW_W+15:16];
          if ({1'b0, x0[31:16]} >= 17'(cur_w)) begin
            // Column outside the grid: nothing of this edge lands.
            if (ek + 1'b1 == edge_count) begin
              state <= (cur_h >= DW'(3)) ? S_FILL_RD : S_EMIT_RD;
              row   <= (cur_h >= DW'(3)) ? ROW_W'(1) : '0;
            end else begin
              ek    <= ek + 1'b1;
              state <= S_EDGE_RD;
            end
          end else if (vert) begin
            lo    <= (y0 < yf) ? $signed({18'b0, y0[31:16]}) : yfb;
            hi    <= (y0 < yf) ? yfb : $signed({18'b0, y0[31:16]});
            state <= S_RUN_START;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            m     <= pos ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
            m_pos <= pos && (mag != '0);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= m * $signed({1'b0, x0[15:0]});
          state <= S_FIRST;
        end
        S_FIRST: begin
          yr <= yr_first;
          if (m_pos) begin
            lo <= $signed({18'b0, y0[31:16]});
            hi <= ROWV_W'(yr_first >>> 16);
          end else begin
            lo <= ROWV_W'(yr_first >>> 16);
            hi <= $signed({18'b0, y0[31:16]});
          end
          col_last <= ({1'b0, xf[31:16]} < 17'(cur_w)) ? xf[ROW_W+15:16]
                                                        : ROW_W'(cur_w - 1'b1);
          state <= S_RUN_START;
        end
        S_NEXT_COL: begin
          if (col_cur == col_last) begin
            if (ek + 1'b1 == edge_count) begin
              state <= (cur_h >= DW'(3)) ? S_FILL_RD : S_EMIT_RD;
              row   <= (cur_h >= DW'(3)) ? ROW_W'(1) : '0;
            end else begin
              ek    <= ek + 1'b1;
              state <= S_EDGE_RD;
            end
          end else begin
            col_cur <= col_cur + 1'b1;
            yr      <= yr_nx;
            if (m_pos) begin
              lo <= s_nx;
              hi <= (e_nx < yfb) ? e_nx : yfb;
            end else begin
              lo <= (e_nx > yfb) ? e_nx : yfb;
              hi <= s_nx;
            end
            state <= S_RUN_START;
          end
        end
        S_RUN_START: begin
          if (run_empty) begin
            if (!vert) begin
              state <= S_NEXT_COL;
            end else if (ek + 1'b1 == edge_count) begin
              state <= (cur_h >= DW'(3)) ? S_FILL_RD : S_EMIT_RD;
              row   <= (cur_h >= DW'(3)) ? ROW_W'(1) : '0;
            end else begin
              ek    <= ek + 1'b1;
              state <= S_EDGE_RD;
            end
          end else begin
            row     <= lo_c[ROW_W-1:0];
            row_end <= hi_c[ROW_W-1:0];
            state   <= S_RUN_RD;
          end
        end
        S_RUN_RD: begin
          state <= S_RUN_WR;
        end
        S_RUN_WR: begin
          // The write lands before the next read, so no forwarding is needed.
          if (row != row_end) begin
            row   <= row + 1'b1;
            state <= S_RUN_RD;
          end else if (!vert) begin
            state <= S_NEXT_COL;
          end else if (ek + 1'b1 == edge_count) begin
            state <= (cur_h >= DW'(3)) ? S_FILL_RD : S_EMIT_RD;
            row   <= (cur_h >= DW'(3)) ? ROW_W'(1) : '0;
          end else begin
            ek    <= ek + 1'b1;
            state <= S_EDGE_RD;
          end
        end
        S_FILL_RD: begin
          state <= S_FILL_A;
        end
        S_FILL_A: begin
          frow   <= grid_q;
          above1 <= ~(fe ^ fem1);
          e2     <= fe & fem1;
          state  <= S_FILL_B;
        end
        S_FILL_B: begin
          if (row == ROW_W'(cur_h - DW'(2))) begin
            row   <= '0;
            state <= S_EMIT_RD;
          end else begin
            row   <= row + 1'b1;
            state <= S_FILL_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (emit_go) begin
            out_valid   <= 1'b1;
            row_bits    <= ROW_BITS_W'(grid_q & wmask);
            row_index   <= ROW_IDX_W'(row);
            origin_x    <= min_x;
            origin_y    <= min_y;
            grid_width  <= DIM_W'(cur_w);
            grid_height <= DIM_W'(cur_h);
            tag_out     <= held_tag;
            too_large   <= big;
            last_row    <= (row == h_last);
            if (row == h_last) begin
              min_x      <= '1;
              min_y      <= '1;
              max_x      <= '0;
              max_y      <= '0;
              edge_count <= '0;
              state      <= S_IDLE;
            end else begin
              row   <= row + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The edge store never holds more than its depth.
  property p_count_bound;
    @(posedge clk) disable iff (rst) edge_count <= CW'(MAX_EDGES);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("edge count overflow");

  // Grid writes of a run stay inside the box height.
  property p_run_row;
    @(posedge clk) disable iff (rst) (state == S_RUN_WR) |-> (row <= h_last);
  endproperty
  a_run_row: assert property (p_run_row) else $error("run write outside the grid");

  // The divider only finishes while the sequencer waits for it.
  property p_div_wait;
    @(posedge clk) disable iff (rst) div_done |-> (state == S_DIV);
  endproperty
  a_div_wait: assert property (p_div_wait) else $error("slope ready outside the wait");

  // After the final row the box is reset and new edges are taken.
  property p_last_row_clear;
    @(posedge clk) disable iff (rst) (emit_go && (row == h_last)) |=>
      (state == S_IDLE) && (edge_count == '0) && last_row && out_valid;
  endproperty
  a_last_row_clear: assert property (p_last_row_clear) else $error("polygon not closed");

endmodule
